### src/two_level_strict_priority_pdu_queue_unit_assert.svh
// assertion macros used by the queue unit datapath
`ifndef TWO_LEVEL_STRICT_PRIORITY_PDU_QUEUE_UNIT_ASSERT_SVH
`define TWO_LEVEL_STRICT_PRIORITY_PDU_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define TLSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define TLSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tlsp_pkg.sv
// shared types, codes and field widths of the pdu queue unit
package tlsp_pkg;

  localparam int OPCODE_W = 2;
  localparam int HANDLE_W = 16;
  localparam int LENGTH_W = 11;
  localparam int SAPI_W   = 4;
  localparam int RPRIO_W  = 8;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OUT_RP_W = 3;
  localparam int PKT_W    = 8;
  localparam int OCT_W    = 19;
  localparam int AVG_W    = 32;

  // request opcodes
  localparam logic [OPCODE_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // llc sapi numbers
  localparam logic [SAPI_W-1:0] SAPI_GMM  = 4'd1;
  localparam logic [SAPI_W-1:0] SAPI_TOM2 = 4'd2;
  localparam logic [SAPI_W-1:0] SAPI_SMS  = 4'd7;
  localparam logic [SAPI_W-1:0] SAPI_TOM8 = 4'd8;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [LENGTH_W-1:0] length;
    logic [TIME_W-1:0]   arrival;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic capture;
    logic execute;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic deq_hit;
    logic out_free;
  } ctrl_sts_t;

  // unsaturated sapi class: gmm, then tom2/sms/tom8, then the rest
  function automatic logic [1:0] sapi_class_raw(input logic [SAPI_W-1:0] sapi);
    logic [1:0] c;
    if (sapi == SAPI_GMM) begin
      c = 2'd0;
    end else if (sapi == SAPI_TOM2 || sapi == SAPI_SMS || sapi == SAPI_TOM8) begin
      c = 2'd1;
    end else begin
      c = 2'd2;
    end
    return c;
  endfunction

endpackage

### src/tlsp_if.sv
// request and result channel interfaces
interface tlsp_req_if;
  import tlsp_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [HANDLE_W-1:0] pdu_handle;
  logic [LENGTH_W-1:0] pdu_length;
  logic [SAPI_W-1:0]   sapi;
  logic [RPRIO_W-1:0]  radio_priority;
  logic [TIME_W-1:0]   now_ms;

  modport source (
    output valid, opcode, pdu_handle, pdu_length, sapi, radio_priority, now_ms,
    input  ready
  );
  modport sink (
    input  valid, opcode, pdu_handle, pdu_length, sapi, radio_priority, now_ms,
    output ready
  );
endinterface

interface tlsp_rsp_if;
  import tlsp_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] out_handle;
  logic [LENGTH_W-1:0] out_length;
  logic [OUT_RP_W-1:0] out_radio_priority;
  logic [PKT_W-1:0]    total_packets;
  logic [OCT_W-1:0]    total_octets;
  logic [AVG_W-1:0]    average_delay_ms;
  logic [OUT_RP_W-1:0] highest_pending_priority;

  modport source (
    output valid, status, out_handle, out_length, out_radio_priority, total_packets,
           total_octets, average_delay_ms, highest_pending_priority,
    input  ready
  );
  modport sink (
    input  valid, status, out_handle, out_length, out_radio_priority, total_packets,
           total_octets, average_delay_ms, highest_pending_priority,
    output ready
  );
endinterface

### src/tlsp_ram.sv
// generic single-port ram with registered read
module tlsp_ram #(
  parameter  int WIDTH = 59,
  parameter  int DEPTH = 192,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/tlsp_ctrl.sv
// controller state machine of the pdu queue unit
module tlsp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tlsp_pkg::ctrl_sts_t   sts_i,
  output tlsp_pkg::ctrl_cmd_t   cmd_o
);
  import tlsp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register can take the outcome
        if (sts_i.out_free) begin
          cmd_o.execute = 1'b1;
          state_d       = sts_i.deq_hit ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/tlsp_dpath.sv
// datapath: class pointers, entry ram, totals, average delay, result register
`include "two_level_strict_priority_pdu_queue_unit_assert.svh"
module tlsp_dpath #(
  parameter int CLASS_DEPTH  = 16,
  parameter int RADIO_LEVELS = 4,
  parameter int SAPI_LEVELS  = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tlsp_pkg::ctrl_cmd_t             cmd_i,
  output tlsp_pkg::ctrl_sts_t             sts_o,
  input  logic [tlsp_pkg::OPCODE_W-1:0]   opcode_i,
  input  logic [tlsp_pkg::HANDLE_W-1:0]   pdu_handle_i,
  input  logic [tlsp_pkg::LENGTH_W-1:0]   pdu_length_i,
  input  logic [tlsp_pkg::SAPI_W-1:0]     sapi_i,
  input  logic [tlsp_pkg::RPRIO_W-1:0]    radio_priority_i,
  input  logic [tlsp_pkg::TIME_W-1:0]     now_ms_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [tlsp_pkg::STATUS_W-1:0]   status_o,
  output logic [tlsp_pkg::HANDLE_W-1:0]   out_handle_o,
  output logic [tlsp_pkg::LENGTH_W-1:0]   out_length_o,
  output logic [tlsp_pkg::OUT_RP_W-1:0]   out_radio_priority_o,
  output logic [tlsp_pkg::PKT_W-1:0]      total_packets_o,
  output logic [tlsp_pkg::OCT_W-1:0]      total_octets_o,
  output logic [tlsp_pkg::AVG_W-1:0]      average_delay_ms_o,
  output logic [tlsp_pkg::OUT_RP_W-1:0]   highest_pending_priority_o
);
  import tlsp_pkg::*;

  localparam int NUM_CLASSES = RADIO_LEVELS * SAPI_LEVELS;
  localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int R_IDX_W     = (RADIO_LEVELS > 1) ? $clog2(RADIO_LEVELS) : 1;
  localparam int RLV_W       = $clog2(RADIO_LEVELS + 1);
  localparam int PTR_W       = $clog2(CLASS_DEPTH);
  localparam int CNT_W       = $clog2(CLASS_DEPTH + 1);
  localparam int SUM_W       = $clog2(2 * CLASS_DEPTH);
  localparam int STORE_DEPTH = NUM_CLASSES * CLASS_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  typedef struct packed {
    logic             found;
    logic [CLS_W-1:0] idx;
    logic [RLV_W-1:0] prio;
  } pick_t;

  // first non-empty class, radio priority 1 first, sapi class 0 first
  function automatic pick_t pick_first(input logic [NUM_CLASSES-1:0] nz);
    pick_t p;
    p = '0;
    for (int r = RADIO_LEVELS - 1; r >= 0; r--) begin
      for (int s = SAPI_LEVELS - 1; s >= 0; s--) begin
        if (nz[r * SAPI_LEVELS + s]) begin
          p.found = 1'b1;
          p.idx   = CLS_W'(r * SAPI_LEVELS + s);
          p.prio  = RLV_W'(r + 1);
        end
      end
    end
    return p;
  endfunction

  // captured request
  logic [OPCODE_W-1:0] op_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [LENGTH_W-1:0] length_q;
  logic [SAPI_W-1:0]   sapi_q;
  logic [RPRIO_W-1:0]  rprio_q;
  logic [TIME_W-1:0]   now_q;

  // class state and running totals
  logic [PTR_W-1:0] head_q  [NUM_CLASSES];
  logic [PTR_W-1:0] head_d  [NUM_CLASSES];
  logic [CNT_W-1:0] count_q [NUM_CLASSES];
  logic [CNT_W-1:0] count_d [NUM_CLASSES];
  logic [PKT_W-1:0] pkt_q, pkt_d;
  logic [OCT_W-1:0] oct_q, oct_d;
  logic [AVG_W-1:0] avg_q, avg_d;
  logic [RLV_W-1:0] deq_prio_q;

  // result register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [HANDLE_W-1:0] out_handle_q;
  logic [LENGTH_W-1:0] out_length_q;
  logic [OUT_RP_W-1:0] out_rprio_q;
  logic [PKT_W-1:0]    out_pkt_q;
  logic [OCT_W-1:0]    out_oct_q;
  logic [AVG_W-1:0]    out_avg_q;
  logic [OUT_RP_W-1:0] out_hp_q;

  logic [NUM_CLASSES-1:0] nz_q, nz_post;
  pick_t                  deq_pick, post_pick;
  logic [R_IDX_W-1:0]     enq_r;
  logic [1:0]             sapi_raw, enq_s;
  logic [CLS_W-1:0]       enq_cls, acc_cls;
  logic                   enq_full, deq_hit;
  logic [SUM_W-1:0]       slot_sum;
  logic [PTR_W-1:0]       enq_slot, head_next, acc_off;
  logic [ADDR_W-1:0]      ram_addr;
  logic                   ram_we, ram_re;
  entry_t                 wr_entry, rd_entry;
  logic [TIME_W-1:0]      lifetime;
  logic [AVG_W:0]         avg_sum;
  logic                   out_free, out_load;
  logic [STATUS_W-1:0]    res_status;
  logic [HANDLE_W-1:0]    res_handle;
  logic [LENGTH_W-1:0]    res_length;
  logic [RLV_W-1:0]       res_rprio;

  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      nz_q[i] = (count_q[i] != '0);
    end
  end

  assign deq_pick = pick_first(nz_q);
  assign deq_hit  = (op_q == OP_DEQUEUE) && deq_pick.found;

  // class of an enqueue: clamped radio priority, saturated sapi class
  always_comb begin
    if (rprio_q == '0) begin
      enq_r = '0;
    end else if (rprio_q > RPRIO_W'(RADIO_LEVELS)) begin
      enq_r = R_IDX_W'(RADIO_LEVELS - 1);
    end else begin
      enq_r = R_IDX_W'(rprio_q - RPRIO_W'(1));
    end
    sapi_raw = sapi_class_raw(sapi_q);
    if (int'(sapi_raw) > SAPI_LEVELS - 1) begin
      enq_s = 2'(SAPI_LEVELS - 1);
    end else begin
      enq_s = sapi_raw;
    end
    enq_cls = CLS_W'(int'(enq_r) * SAPI_LEVELS + int'(enq_s));
  end

  assign enq_full = (count_q[enq_cls] == CNT_W'(CLASS_DEPTH));

  // tail slot, wrapped once at most
  assign slot_sum = SUM_W'(head_q[enq_cls]) + SUM_W'(count_q[enq_cls]);
  assign enq_slot = (slot_sum >= SUM_W'(CLASS_DEPTH)) ?
                    PTR_W'(slot_sum - SUM_W'(CLASS_DEPTH)) : PTR_W'(slot_sum);

  assign head_next = (head_q[deq_pick.idx] == PTR_W'(CLASS_DEPTH - 1)) ?
                     '0 : head_q[deq_pick.idx] + 1'b1;

  assign acc_cls  = (op_q == OP_DEQUEUE) ? deq_pick.idx : enq_cls;
  assign acc_off  = (op_q == OP_DEQUEUE) ? head_q[deq_pick.idx] : enq_slot;
  assign ram_addr = ADDR_W'(acc_cls) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(acc_off);
  assign wr_entry = '{handle: handle_q, length: length_q, arrival: now_q};

  tlsp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (wr_entry),
    .rdata_o (rd_entry)
  );

  assign lifetime = now_q - rd_entry.arrival;
  assign avg_sum  = {1'b0, avg_q} + {1'b0, lifetime};

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    pkt_d      = pkt_q;
    oct_d      = oct_q;
    avg_d      = avg_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    nz_post    = nz_q;
    res_status = STATUS_DONE;
    res_handle = '0;
    res_length = '0;
    res_rprio  = '0;
    out_load   = 1'b0;
    if (cmd_i.execute) begin
      case (op_q)
        OP_ENQUEUE: begin
          if (!enq_full) begin
            ram_we           = 1'b1;
            count_d[enq_cls] = count_q[enq_cls] + 1'b1;
            pkt_d            = pkt_q + 1'b1;
            oct_d            = oct_q + OCT_W'(length_q);
            nz_post[enq_cls] = 1'b1;
          end else begin
            res_status = STATUS_FULL;
          end
        end
        OP_DEQUEUE: begin
          if (deq_pick.found) begin
            ram_re                = 1'b1;
            head_d[deq_pick.idx]  = head_next;
            count_d[deq_pick.idx] = count_q[deq_pick.idx] - 1'b1;
            pkt_d                 = pkt_q - 1'b1;
          end else begin
            res_status = STATUS_EMPTY;
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < NUM_CLASSES; i++) begin
            head_d[i]  = '0;
            count_d[i] = '0;
          end
          pkt_d   = '0;
          oct_d   = '0;
          nz_post = '0;
        end
        default: begin
        end
      endcase
      out_load = !deq_hit;
    end else if (cmd_i.finish) begin
      // head entry is in the ram read register now
      oct_d      = oct_q - OCT_W'(rd_entry.length);
      avg_d      = avg_sum[AVG_W:1];
      res_handle = rd_entry.handle;
      res_length = rd_entry.length;
      res_rprio  = deq_prio_q;
      out_load   = 1'b1;
    end
  end

  assign post_pick = pick_first(nz_post);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= opcode_i;
      handle_q <= pdu_handle_i;
      length_q <= pdu_length_i;
      sapi_q   <= sapi_i;
      rprio_q  <= radio_priority_i;
      now_q    <= now_ms_i;
    end
    if (cmd_i.execute) begin
      deq_prio_q <= deq_pick.prio;
    end
    if (out_load) begin
      out_status_q <= res_status;
      out_handle_q <= res_handle;
      out_length_q <= res_length;
      out_rprio_q  <= OUT_RP_W'(res_rprio);
      out_pkt_q    <= pkt_d;
      out_oct_q    <= oct_d;
      out_avg_q    <= avg_d;
      out_hp_q     <= OUT_RP_W'(post_pick.prio);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
      pkt_q       <= '0;
      oct_q       <= '0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      pkt_q   <= pkt_d;
      oct_q   <= oct_d;
      avg_q   <= avg_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.deq_hit  = deq_hit;
  assign sts_o.out_free = out_free;

  assign out_valid_o                = out_valid_q;
  assign status_o                   = out_status_q;
  assign out_handle_o               = out_handle_q;
  assign out_length_o               = out_length_q;
  assign out_radio_priority_o       = out_rprio_q;
  assign total_packets_o            = out_pkt_q;
  assign total_octets_o             = out_oct_q;
  assign average_delay_ms_o         = out_avg_q;
  assign highest_pending_priority_o = out_hp_q;

  `TLSP_ASSERT_IMP(a_empty_no_packets, nz_q == '0, pkt_q == '0, "packet total nonzero with every class empty")
  `TLSP_ASSERT_NEXT(a_full_keeps_total, cmd_i.execute && op_q == OP_ENQUEUE && enq_full, $stable(pkt_q), "rejected enqueue changed the packet total")
  `TLSP_ASSERT_NEXT(a_hit_has_priority, cmd_i.execute && deq_hit, deq_prio_q != '0, "dequeue hit without a radio priority")
  `TLSP_ASSERT_IMP(a_load_only_when_free, out_load, out_free, "result register overwritten while held")

endmodule

### src/two_level_strict_priority_pdu_queue_unit.sv
// top level of the two-level strict-priority pdu descriptor queue
//
//  channel  dir  handshake      payload
//  req_i    in   valid/ready    opcode, pdu_handle, pdu_length, sapi, radio_priority, now_ms
//  rsp_o    out  valid/ready    status, out_handle, out_length, out_radio_priority,
//                               total_packets, total_octets, average_delay_ms,
//                               highest_pending_priority
//
//  enqueue, clear, empty dequeue: steps capture and execute
//  dequeue hit: capture, execute and a read step for the registered read of the single-port entry ram
//  reset clears class pointers, counts, totals and the average; the entry ram needs no pass
//  a held result stalls the unit in execute or read until rsp_o is taken
//  req_i is ready again as soon as the result is loaded into the output register
module two_level_strict_priority_pdu_queue_unit #(
  parameter int CLASS_DEPTH  = 16,
  parameter int RADIO_LEVELS = 4,
  parameter int SAPI_LEVELS  = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tlsp_req_if.sink          req_i,
  tlsp_rsp_if.source        rsp_o
);
  import tlsp_pkg::*;

  // command and status between controller and datapath
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // controller: one request at a time, ready only while idle
  tlsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: class fifos over a shared entry ram, totals and result register
  tlsp_dpath #(
    .CLASS_DEPTH  (CLASS_DEPTH),
    .RADIO_LEVELS (RADIO_LEVELS),
    .SAPI_LEVELS  (SAPI_LEVELS)
  ) u_dpath (
    .clk_i                      (clk_i),
    .rst_ni                     (rst_ni),
    .cmd_i                      (cmd),
    .sts_o                      (sts),
    .opcode_i                   (req_i.opcode),
    .pdu_handle_i               (req_i.pdu_handle),
    .pdu_length_i               (req_i.pdu_length),
    .sapi_i                     (req_i.sapi),
    .radio_priority_i           (req_i.radio_priority),
    .now_ms_i                   (req_i.now_ms),
    .out_ready_i                (rsp_o.ready),
    .out_valid_o                (rsp_o.valid),
    .status_o                   (rsp_o.status),
    .out_handle_o               (rsp_o.out_handle),
    .out_length_o               (rsp_o.out_length),
    .out_radio_priority_o       (rsp_o.out_radio_priority),
    .total_packets_o            (rsp_o.total_packets),
    .total_octets_o             (rsp_o.total_octets),
    .average_delay_ms_o         (rsp_o.average_delay_ms),
    .highest_pending_priority_o (rsp_o.highest_pending_priority)
  );

endmodule

### tb/sv/tb_two_level_strict_priority_pdu_queue_unit.sv
// self-checking testbench of the strict-priority pdu queue unit: random traffic, scoreboard
module tb_two_level_strict_priority_pdu_queue_unit;
  import tlsp_pkg::*;

  // geometry of the unit under test, kept at its defaults
  localparam int CLASS_DEPTH  = 16;
  localparam int RADIO_LEVELS = 4;
  localparam int SAPI_LEVELS  = 3;
  localparam int NUM_CLASSES  = RADIO_LEVELS * SAPI_LEVELS;
  localparam int HEAD_W       = $clog2(CLASS_DEPTH);
  localparam int CNT_W        = HEAD_W + 1;

  // the one opcode the package leaves unnamed: the unit must ignore it
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // run shaping
  localparam int TARGET_ITEMS   = 750;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AT_FIRST  = 120;
  localparam int HOLD_AT_SECOND = 480;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  // one request as the sender queues it
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [HANDLE_W-1:0] handle;
    logic [LENGTH_W-1:0] length;
    logic [SAPI_W-1:0]   sapi;
    logic [RPRIO_W-1:0]  rprio;
    logic [TIME_W-1:0]   now;
    logic                wait_idle;   // hold back until every result is in
  } pdu_req_t;

  // one result as the unit reports it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
    logic [LENGTH_W-1:0] length;
    logic [OUT_RP_W-1:0] rprio;
    logic [PKT_W-1:0]    packets;
    logic [OCT_W-1:0]    octets;
    logic [AVG_W-1:0]    avg_delay;
    logic [OUT_RP_W-1:0] highest;
  } queue_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tlsp_req_if req_if ();
  tlsp_rsp_if rsp_if ();

  two_level_strict_priority_pdu_queue_unit #(
    .CLASS_DEPTH  (CLASS_DEPTH),
    .RADIO_LEVELS (RADIO_LEVELS),
    .SAPI_LEVELS  (SAPI_LEVELS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // queue mirror: class fifos, totals and the running delay average
  // ---------------------------------------------------------------------------
  entry_t            mirror_store [NUM_CLASSES][CLASS_DEPTH];
  bit [HEAD_W-1:0]   mirror_head  [NUM_CLASSES];
  bit [CNT_W-1:0]    mirror_count [NUM_CLASSES];
  bit [PKT_W-1:0]    mirror_packets;
  bit [OCT_W-1:0]    mirror_octets;
  bit [AVG_W-1:0]    mirror_avg;

  queue_result_t queue_results_due [$];
  pdu_req_t      pdu_requests [$];

  int  mismatches;
  int  results_seen;
  int  quiet_cycles;
  int  stim_count;
  bit  timed_out;
  bit  req_taken;

  // sapi to sapi class, saturated to the classes that exist
  function automatic int sapi_group(input logic [SAPI_W-1:0] sp);
    int g;
    if (sp == SAPI_GMM) begin
      g = 0;
    end else if (sp == SAPI_TOM2 || sp == SAPI_SMS || sp == SAPI_TOM8) begin
      g = 1;
    end else begin
      g = 2;
    end
    if (g > SAPI_LEVELS - 1) begin
      g = SAPI_LEVELS - 1;
    end
    return g;
  endfunction

  // strict priority scan: radio priority 1 first, gmm first within it
  function automatic int first_busy_class();
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (mirror_count[c] != 0) begin
        return c;
      end
    end
    return -1;
  endfunction

  // advance the mirror by one accepted request and queue the result it owes
  function automatic void apply_queue_op(input pdu_req_t rq);
    queue_result_t res;
    int            cls;
    int            rp;
    int            slot;
    entry_t        ent;
    logic [TIME_W-1:0] lifetime;
    logic [TIME_W:0]   delay_sum;
    res = '0;
    res.status = STATUS_DONE;
    case (rq.opcode)
      OP_ENQUEUE: begin
        // out-of-range priorities clamp to 1..RADIO_LEVELS
        rp = rq.rprio;
        if (rp < 1) begin
          rp = 1;
        end
        if (rp > RADIO_LEVELS) begin
          rp = RADIO_LEVELS;
        end
        cls = (rp - 1) * SAPI_LEVELS + sapi_group(rq.sapi);
        if (mirror_count[cls] >= CLASS_DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          slot = (int'(mirror_head[cls]) + int'(mirror_count[cls])) % CLASS_DEPTH;
          ent.handle  = rq.handle;
          ent.length  = rq.length;
          ent.arrival = rq.now;
          mirror_store[cls][slot] = ent;
          mirror_count[cls]++;
          mirror_packets++;
          mirror_octets += rq.length;
        end
      end
      OP_DEQUEUE: begin
        cls = first_busy_class();
        if (cls < 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          ent = mirror_store[cls][mirror_head[cls]];
          // lifetime wraps with the millisecond clock
          lifetime  = rq.now - ent.arrival;
          delay_sum = {1'b0, mirror_avg} + {1'b0, lifetime};
          res.handle = ent.handle;
          res.length = ent.length;
          res.rprio  = OUT_RP_W'(cls / SAPI_LEVELS + 1);
          mirror_head[cls] = HEAD_W'((int'(mirror_head[cls]) + 1) % CLASS_DEPTH);
          mirror_count[cls]--;
          mirror_packets--;
          mirror_octets -= ent.length;
          mirror_avg = delay_sum[TIME_W:1];
        end
      end
      OP_CLEAR: begin
        // the average survives a clear
        for (int c = 0; c < NUM_CLASSES; c++) begin
          mirror_head[c]  = '0;
          mirror_count[c] = '0;
        end
        mirror_packets = '0;
        mirror_octets  = '0;
      end
      default: begin
      end
    endcase
    cls = first_busy_class();
    res.packets   = mirror_packets;
    res.octets    = mirror_octets;
    res.avg_delay = mirror_avg;
    res.highest   = (cls < 0) ? '0 : OUT_RP_W'(cls / SAPI_LEVELS + 1);
    queue_results_due.push_back(res);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: both transfers sampled on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pdu_req_t      seen_req;
    queue_result_t want;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        seen_req.opcode    = req_if.opcode;
        seen_req.handle    = req_if.pdu_handle;
        seen_req.length    = req_if.pdu_length;
        seen_req.sapi      = req_if.sapi;
        seen_req.rprio     = req_if.radio_priority;
        seen_req.now       = req_if.now_ms;
        seen_req.wait_idle = 1'b0;
        apply_queue_op(seen_req);
        req_taken = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (queue_results_due.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding");
        end else begin
          want = queue_results_due.pop_front();
          check_field("status", rsp_if.status, want.status);
          check_field("out_handle", rsp_if.out_handle, want.handle);
          check_field("out_length", rsp_if.out_length, want.length);
          check_field("out_radio_priority", rsp_if.out_radio_priority, want.rprio);
          check_field("total_packets", rsp_if.total_packets, want.packets);
          check_field("total_octets", rsp_if.total_octets, want.octets);
          check_field("average_delay_ms", rsp_if.average_delay_ms, want.avg_delay);
          check_field("highest_pending_priority", rsp_if.highest_pending_priority,
                      want.highest);
        end
      end
      // watchdog: any transfer on either side counts as progress
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // mostly back to back, sometimes a short gap, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: falling edge, fed from the pending request queue
  // ---------------------------------------------------------------------------
  int send_gap;
  bit send_calm;
  bit offer;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 149) == 0) begin
        send_calm = !send_calm;
      end
      offer = req_if.valid;
      if (req_taken) begin
        pdu_requests.pop_front();
        req_taken = 1'b0;
        offer     = 1'b0;
        send_gap  = send_calm ? 0 : pick_gap();
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pdu_requests.size() != 0 &&
                     (!pdu_requests[0].wait_idle || queue_results_due.size() == 0)) begin
          // a marked request waits for the unit to drain completely
          offer = 1'b1;
          req_if.opcode         <= pdu_requests[0].opcode;
          req_if.pdu_handle     <= pdu_requests[0].handle;
          req_if.pdu_length     <= pdu_requests[0].length;
          req_if.sapi           <= pdu_requests[0].sapi;
          req_if.radio_priority <= pdu_requests[0].rprio;
          req_if.now_ms         <= pdu_requests[0].now;
        end
      end
      req_if.valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stalls, plus two long hold-offs while the sender
  // keeps offering, so the unit fills and back-pressures its request side
  // ---------------------------------------------------------------------------
  int recv_gap;
  int hold_left;
  int holds_done;
  bit recv_calm;
  bit take;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 149) == 0) begin
        recv_calm = !recv_calm;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (holds_done < 2 && req_if.valid &&
                   results_seen >= (holds_done == 0 ? HOLD_AT_FIRST : HOLD_AT_SECOND)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
        take = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        take = 1'b0;
      end else begin
        take = 1'b1;
        if (!recv_calm && $urandom_range(0, 4) == 0) begin
          recv_gap = pick_gap();
        end
      end
      rsp_if.ready <= take;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] clock_ms;

  // millisecond clock: small steps, some large ones, rare jumps anywhere
  function automatic logic [TIME_W-1:0] next_now();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      clock_ms += $urandom_range(0, 50);
    end else if (r < 95) begin
      clock_ms += $urandom_range(0, 100000);
    end else begin
      clock_ms = $urandom();
    end
    return clock_ms;
  endfunction

  function automatic logic [SAPI_W-1:0] rand_sapi();
    case ($urandom_range(0, 7))
      0:       return SAPI_GMM;
      1:       return SAPI_TOM2;
      2:       return SAPI_SMS;
      3:       return SAPI_TOM8;
      default: return SAPI_W'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [RPRIO_W-1:0] rand_rprio();
    if ($urandom_range(0, 3) == 0) begin
      return RPRIO_W'($urandom_range(0, 255));
    end
    return RPRIO_W'($urandom_range(0, RADIO_LEVELS + 1));
  endfunction

  function automatic logic [LENGTH_W-1:0] rand_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return LENGTH_W'($urandom_range(0, 2047));
    endcase
  endfunction

  task automatic add_request(input logic [OPCODE_W-1:0] op, input logic [HANDLE_W-1:0] h,
                             input logic [LENGTH_W-1:0] len, input logic [SAPI_W-1:0] sp,
                             input logic [RPRIO_W-1:0] rp, input logic [TIME_W-1:0] t,
                             input bit hold_back);
    pdu_req_t rq;
    rq.opcode    = op;
    rq.handle    = h;
    rq.length    = len;
    rq.sapi      = sp;
    rq.rprio     = rp;
    rq.now       = t;
    rq.wait_idle = hold_back;
    pdu_requests.push_back(rq);
    // the unused opcode is ignored by the unit, so it does not count
    if (op != OP_UNUSED) begin
      stim_count++;
    end
  endtask

  task automatic add_enqueue(input logic [RPRIO_W-1:0] rp, input logic [SAPI_W-1:0] sp,
                             input bit hold_back);
    add_request(OP_ENQUEUE, HANDLE_W'($urandom()), rand_length(), sp, rp, next_now(),
                hold_back);
  endtask

  // dequeue, clear or the unused opcode: the other fields are don't-care noise
  task automatic add_command(input logic [OPCODE_W-1:0] op, input bit hold_back);
    add_request(op, HANDLE_W'($urandom()), rand_length(), SAPI_W'($urandom_range(0, 15)),
                RPRIO_W'($urandom_range(0, 255)), next_now(), hold_back);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int                 kind;
    int                 n;
    int                 r;
    bit                 hold_back;
    bit                 first_seq;
    logic [RPRIO_W-1:0] burst_rp;
    logic [SAPI_W-1:0]  burst_sapi;

    rst_ni                = 1'b0;
    req_if.valid          = 1'b0;
    req_if.opcode         = OP_ENQUEUE;
    req_if.pdu_handle     = '0;
    req_if.pdu_length     = '0;
    req_if.sapi           = '0;
    req_if.radio_priority = '0;
    req_if.now_ms         = '0;
    rsp_if.ready          = 1'b0;
    clock_ms              = '0;

    // directed: empty queue, ignored opcode, clear when empty
    add_request(OP_DEQUEUE, '0, '0, '0, '0, 32'd0, 1'b0);
    add_request(OP_UNUSED, '1, '1, '1, '1, '1, 1'b0);
    add_request(OP_CLEAR, '0, '0, '0, '0, 32'd0, 1'b0);
    // extremes of every field, priority 0 and 255 clamped
    add_request(OP_ENQUEUE, '0, '0, SAPI_GMM, 8'd0, 32'd0, 1'b0);
    add_request(OP_ENQUEUE, '1, '1, 4'd15, 8'd255, 32'hffff_ffff, 1'b0);
    // every sapi class, spread across the radio priorities
    add_request(OP_ENQUEUE, 16'd1, 11'd100, SAPI_TOM2, 8'd1, 32'd10, 1'b0);
    add_request(OP_ENQUEUE, 16'd2, 11'd200, SAPI_SMS, 8'd2, 32'd20, 1'b0);
    add_request(OP_ENQUEUE, 16'd3, 11'd300, SAPI_TOM8, 8'd3, 32'd30, 1'b0);
    add_request(OP_ENQUEUE, 16'd4, 11'd400, 4'd0, 8'd4, 32'd40, 1'b0);
    add_request(OP_ENQUEUE, 16'd5, 11'd500, 4'd3, 8'd5, 32'd50, 1'b0);
    add_request(OP_ENQUEUE, 16'd6, 11'd600, SAPI_GMM, 8'd1, 32'd60, 1'b0);
    // strict priority drain order, then a lifetime across the time wrap
    add_request(OP_DEQUEUE, '0, '0, '0, '0, 32'd100, 1'b0);
    add_request(OP_DEQUEUE, '0, '0, '0, '0, 32'd110, 1'b0);
    add_request(OP_DEQUEUE, '0, '0, '0, '0, 32'd120, 1'b0);
    add_request(OP_DEQUEUE, '0, '0, '0, '0, 32'd130, 1'b0);
    add_request(OP_DEQUEUE, '0, '0, '0, '0, 32'd140, 1'b0);
    add_request(OP_DEQUEUE, '0, '0, '0, '0, 32'd5, 1'b0);
    add_request(OP_DEQUEUE, '0, '0, '0, '0, 32'hffff_ffff, 1'b0);
    // clear with entries pending keeps the average, then an empty dequeue
    add_request(OP_ENQUEUE, 16'h00ff, 11'd7, 4'd9, 8'd3, 32'd1000, 1'b0);
    add_request(OP_CLEAR, '0, '0, '0, '0, 32'd1001, 1'b0);
    add_request(OP_DEQUEUE, '0, '0, '0, '0, 32'd1002, 1'b0);
    add_request(OP_ENQUEUE, 16'h8000, 11'h400, SAPI_GMM, 8'd4, 32'h8000_0000, 1'b0);
    add_request(OP_DEQUEUE, '0, '0, '0, '0, 32'h7fff_ffff, 1'b0);

    // random sequences; the first one bursts into one class, usually past full, and waits for idle
    first_seq = 1'b1;
    while (stim_count < TARGET_ITEMS) begin
      kind      = first_seq ? 50 : $urandom_range(0, 99);
      hold_back = first_seq || ($urandom_range(0, 9) == 0);
      first_seq = 1'b0;
      if (kind < 40) begin
        // mixed traffic
        n = $urandom_range(5, 30);
        for (int i = 0; i < n; i++) begin
          r = $urandom_range(0, 99);
          if (r < 55) begin
            add_enqueue(rand_rprio(), rand_sapi(), hold_back);
          end else if (r < 96) begin
            add_command(OP_DEQUEUE, hold_back);
          end else if (r < 98) begin
            add_command(OP_CLEAR, hold_back);
          end else begin
            add_command(OP_UNUSED, hold_back);
          end
          hold_back = 1'b0;
        end
      end else if (kind < 60) begin
        // burst into one class, usually past full, then a few dequeues
        burst_rp   = rand_rprio();
        burst_sapi = rand_sapi();
        n = $urandom_range(CLASS_DEPTH - 2, CLASS_DEPTH + 4);
        for (int i = 0; i < n; i++) begin
          add_enqueue(burst_rp, burst_sapi, hold_back);
          hold_back = 1'b0;
        end
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          add_command(OP_DEQUEUE, 1'b0);
        end
      end else if (kind < 80) begin
        // drain run, often past empty
        n = $urandom_range(5, 40);
        for (int i = 0; i < n; i++) begin
          add_command(OP_DEQUEUE, hold_back);
          hold_back = 1'b0;
        end
      end else if (kind < 95) begin
        // wide fill across many classes to push the totals up
        n = $urandom_range(20, 60);
        for (int i = 0; i < n; i++) begin
          add_enqueue(rand_rprio(), rand_sapi(), hold_back);
          hold_back = 1'b0;
        end
      end else begin
        // clear, then refill a little
        add_command(OP_CLEAR, hold_back);
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          add_enqueue(rand_rprio(), rand_sapi(), 1'b0);
        end
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    fork
      begin
        while (pdu_requests.size() != 0 || req_if.valid) begin
          @(posedge clk_i);
        end
        while (queue_results_due.size() != 0) begin
          @(posedge clk_i);
        end
        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk_i);
      end
      begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
          @(posedge clk_i);
        end
        timed_out = 1'b1;
      end
    join_any

    if (!timed_out && mismatches == 0 && queue_results_due.size() == 0) begin
      $display("two_level_strict_priority_pdu_queue_unit: match");
    end else begin
      $display("two_level_strict_priority_pdu_queue_unit: mismatch");
    end
    $finish;
  end

endmodule
